// ----- rtl/tcf_pkg.sv -----
// Shared types, constants and angle tables for the tilt complementary filter.
package tcf_pkg;

   localparam int ANGLE_FRAC_BITS_DEF = 16;
   localparam int CORDIC_STEPS_DEF    = 16;
   localparam int CORDIC_MAX_STEPS    = 24;
   localparam int STEP_W              = 5;

   localparam int XY_W   = 36;  // CORDIC x/y: 17-bit count << 16 plus gain growth
   localparam int ANG_W  = 34;  // CORDIC angle accumulator
   localparam int SUM_W  = 36;  // wide sums ahead of saturation
   localparam int MULA_W = 25;
   localparam int MULB_W = 34;
   localparam int PROD_W = MULA_W + MULB_W;

   localparam int BLEND_GAIN_W = 16;
   localparam int STEP_SCALE_W = 24;
   localparam int CSR_INDEX_W  = 1;
   localparam int CSR_DATA_W   = 24;

   localparam logic [BLEND_GAIN_W-1:0] BLEND_GAIN_RST = 16'd385;
   localparam logic [STEP_SCALE_W-1:0] STEP_SCALE_RST = 24'd45740;

   localparam logic [CSR_INDEX_W-1:0] CSR_BLEND_GAIN = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_STEP_SCALE = 1'd1;

   localparam longint PI_Q30 = 64'sd3373259426;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CORDIC,
      ST_MUL_GYRO,
      ST_MUL_LP,
      ST_MUL_HP,
      ST_HP,
      ST_FINISH
   } state_type;

   // Q2.30 constant rounded half up to the angle format.
   function automatic logic signed [ANG_W-1:0] q30_round(input longint v, input int frac);
      longint s;
      s = 30 - frac;
      return ANG_W'((v + (64'sd1 <<< (s - 1))) >>> s);
   endfunction

   function automatic logic signed [ANG_W-1:0] pi_angle(input int frac);
      return q30_round(PI_Q30, frac);
   endfunction

   // atan(2^-i) in the angle format
   function automatic logic signed [ANG_W-1:0] atan_angle(input logic [STEP_W-1:0] idx,
                                                          input int frac);
      longint a;
      case (idx)
         5'd0:  a = 843314857;
         5'd1:  a = 497837829;
         5'd2:  a = 263043837;
         5'd3:  a = 133525159;
         5'd4:  a = 67021687;
         5'd5:  a = 33543516;
         5'd6:  a = 16775851;
         5'd7:  a = 8388437;
         5'd8:  a = 4194283;
         5'd9:  a = 2097149;
         5'd10: a = 1048576;
         5'd11: a = 524288;
         5'd12: a = 262144;
         5'd13: a = 131072;
         5'd14: a = 65536;
         5'd15: a = 32768;
         5'd16: a = 16384;
         5'd17: a = 8192;
         5'd18: a = 4096;
         5'd19: a = 2048;
         5'd20: a = 1024;
         5'd21: a = 512;
         5'd22: a = 256;
         5'd23: a = 128;
         default: a = 0;
      endcase
      return q30_round(a, frac);
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [SUM_W-1:0] v);
      logic signed [SUM_W-1:0] hi;
      logic signed [SUM_W-1:0] lo;
      hi = SUM_W'(64'sd2147483647);
      lo = SUM_W'(-64'sd2147483648);
      if (v > hi) begin
         return 32'sh7FFFFFFF;
      end else if (v < lo) begin
         return 32'sh80000000;
      end else begin
         return v[31:0];
      end
   endfunction

endpackage

// ----- rtl/tilt_complementary_filter.sv -----
// Tilt complementary filter: CORDIC tilt angle, gyro integrator, LP/HP blend.
// After a request is accepted the CORDIC iterations run, one per cycle, with
// STEPS = min(CORDIC_STEPS, 24); then MUL_GYRO, MUL_LP, MUL_HP, HP and FINISH,
// where rsp_valid rises. Requests do not overlap: req_stall is high outside IDLE,
// as the single CORDIC stage and the shared multiplier (three uses) serve each.
// Reset (synchronous, active high) clears the integrator and filter history and
// loads blend_gain = 385, gyro_step_scale = 45740.
module tilt_complementary_filter #(
   parameter int ANGLE_FRAC_BITS = tcf_pkg::ANGLE_FRAC_BITS_DEF,
   parameter int CORDIC_STEPS    = tcf_pkg::CORDIC_STEPS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [15:0]                  req_accel_y,
   input  logic signed [15:0]                  req_accel_z,
   input  logic signed [15:0]                  req_gyro_x,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [31:0]                  rsp_accel_angle_raw,
   output logic signed [31:0]                  rsp_gyro_angle_raw,
   output logic signed [31:0]                  rsp_accel_angle_low_passed,
   output logic signed [31:0]                  rsp_gyro_angle_high_passed,
   output logic signed [31:0]                  rsp_fused_angle,
   input  logic                                csr_write_enable,
   input  logic [tcf_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [tcf_pkg::CSR_DATA_W-1:0]      csr_write_data
);

   localparam int STEPS = (CORDIC_STEPS > tcf_pkg::CORDIC_MAX_STEPS) ?
                          tcf_pkg::CORDIC_MAX_STEPS : CORDIC_STEPS;
   localparam int GYRO_SHIFT = 32 - ANGLE_FRAC_BITS;
   localparam logic [tcf_pkg::STEP_W-1:0] LAST_STEP = tcf_pkg::STEP_W'(STEPS - 1);
   localparam logic signed [tcf_pkg::ANG_W-1:0] PI_ANG = tcf_pkg::pi_angle(ANGLE_FRAC_BITS);
   localparam logic signed [tcf_pkg::PROD_W-1:0] ROUND_HALF = tcf_pkg::PROD_W'(32768);

   tcf_pkg::state_type state_ff, state_in;

   logic [tcf_pkg::BLEND_GAIN_W-1:0] blend_gain_ff;
   logic [tcf_pkg::STEP_SCALE_W-1:0] step_scale_ff;

   logic signed [31:0] gyro_integrator_ff;
   logic signed [31:0] prev_accel_angle_ff;
   logic signed [31:0] prev_accel_filtered_ff;
   logic signed [31:0] prev_gyro_angle_ff;
   logic signed [31:0] prev_gyro_filtered_ff;

   logic signed [tcf_pkg::XY_W-1:0]   x_ff, y_ff;
   logic signed [tcf_pkg::ANG_W-1:0]  ang_ff;
   logic [tcf_pkg::STEP_W-1:0]        cnt_ff;
   logic                              zero_ff;
   logic signed [15:0]                gyro_x_ff;
   logic signed [tcf_pkg::PROD_W-1:0] prod_ff;
   logic signed [31:0]                g_raw_ff, a_lp_ff, g_hp_ff;

   logic                              rsp_valid_ff;
   logic signed [31:0]                out_a_raw_ff, out_g_raw_ff, out_a_lp_ff;
   logic signed [31:0]                out_g_hp_ff, out_fused_ff;

   // combinational datapath
   logic                              req_fire, rsp_fire, finish_fire;
   logic signed [16:0]                num_w;
   logic signed [tcf_pkg::XY_W-1:0]   x_init, y_init;
   logic signed [tcf_pkg::XY_W-1:0]   xs_w, ys_w;
   logic signed [tcf_pkg::ANG_W-1:0]  t_w;
   logic signed [tcf_pkg::MULA_W-1:0] mul_a;
   logic signed [tcf_pkg::MULB_W-1:0] mul_b;
   logic signed [tcf_pkg::PROD_W-1:0] prod_in;
   logic signed [32:0]                diff_w;
   logic signed [tcf_pkg::PROD_W-1:0] shifted_w;
   logic signed [tcf_pkg::SUM_W-1:0]  sum_w;
   logic signed [31:0]                a_raw_w;
   logic signed [31:0]                fused_w;

   assign req_fire    = req_valid && !req_stall;
   assign rsp_fire    = rsp_valid_ff && !rsp_stall;
   assign finish_fire = (state_ff == tcf_pkg::ST_FINISH) && (!rsp_valid_ff || !rsp_stall);
   assign req_stall   = (state_ff != tcf_pkg::ST_IDLE);

   assign rsp_valid                  = rsp_valid_ff;
   assign rsp_accel_angle_raw        = out_a_raw_ff;
   assign rsp_gyro_angle_raw         = out_g_raw_ff;
   assign rsp_accel_angle_low_passed = out_a_lp_ff;
   assign rsp_gyro_angle_high_passed = out_g_hp_ff;
   assign rsp_fused_angle            = out_fused_ff;

   // atan2(-z, y): numerator is -accel_z, denominator accel_y, both scaled by 2^16
   assign num_w  = -$signed({req_accel_z[15], req_accel_z});
   assign x_init = $signed({{4{req_accel_y[15]}}, req_accel_y, 16'b0});
   assign y_init = $signed({{3{num_w[16]}}, num_w, 16'b0});

   assign xs_w = x_ff >>> cnt_ff;
   assign ys_w = y_ff >>> cnt_ff;
   assign t_w  = tcf_pkg::atan_angle(cnt_ff, ANGLE_FRAC_BITS);

   assign diff_w  = $signed({prev_accel_angle_ff[31], prev_accel_angle_ff})
                  - $signed({prev_accel_filtered_ff[31], prev_accel_filtered_ff});
   assign prod_in = mul_a * mul_b;

   assign a_raw_w = zero_ff ? 32'sd0 : tcf_pkg::sat32(tcf_pkg::SUM_W'(ang_ff));
   assign fused_w = tcf_pkg::sat32(tcf_pkg::SUM_W'(a_lp_ff) + tcf_pkg::SUM_W'(g_hp_ff));

   // sequencer and shared multiplier operand select
   always_comb begin
      state_in  = state_ff;
      mul_a     = '0;
      mul_b     = '0;
      shifted_w = '0;
      sum_w     = '0;
      case (state_ff)
         tcf_pkg::ST_IDLE: begin
            if (req_fire) begin
               state_in = tcf_pkg::ST_CORDIC;
            end
         end
         tcf_pkg::ST_CORDIC: begin
            if (cnt_ff == LAST_STEP) begin
               state_in = tcf_pkg::ST_MUL_GYRO;
            end
         end
         tcf_pkg::ST_MUL_GYRO: begin
            mul_a    = $signed({1'b0, step_scale_ff});
            mul_b    = $signed({{18{gyro_x_ff[15]}}, gyro_x_ff});
            state_in = tcf_pkg::ST_MUL_LP;
         end
         tcf_pkg::ST_MUL_LP: begin
            // integrate the gyro increment, then start alpha * (pa - paf)
            shifted_w = prod_ff >>> GYRO_SHIFT;
            sum_w     = $signed(shifted_w[tcf_pkg::SUM_W-1:0])
                      + tcf_pkg::SUM_W'(gyro_integrator_ff);
            mul_a     = $signed({9'b0, blend_gain_ff});
            mul_b     = $signed({diff_w[32], diff_w});
            state_in  = tcf_pkg::ST_MUL_HP;
         end
         tcf_pkg::ST_MUL_HP: begin
            shifted_w = (prod_ff + ROUND_HALF) >>> 16;
            sum_w     = $signed(shifted_w[tcf_pkg::SUM_W-1:0])
                      + tcf_pkg::SUM_W'(prev_accel_filtered_ff);
            mul_a     = $signed({9'b0, blend_gain_ff});
            mul_b     = $signed({{2{prev_gyro_filtered_ff[31]}}, prev_gyro_filtered_ff});
            state_in  = tcf_pkg::ST_HP;
         end
         tcf_pkg::ST_HP: begin
            shifted_w = (prod_ff + ROUND_HALF) >>> 16;
            sum_w     = tcf_pkg::SUM_W'(g_raw_ff) - tcf_pkg::SUM_W'(prev_gyro_angle_ff)
                      + tcf_pkg::SUM_W'(prev_gyro_filtered_ff)
                      - $signed(shifted_w[tcf_pkg::SUM_W-1:0]);
            state_in  = tcf_pkg::ST_FINISH;
         end
         tcf_pkg::ST_FINISH: begin
            if (finish_fire) begin
               state_in = tcf_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tcf_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tcf_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         blend_gain_ff <= tcf_pkg::BLEND_GAIN_RST;
         step_scale_ff <= tcf_pkg::STEP_SCALE_RST;
      end else if (csr_write_enable) begin
         case (csr_index)
            tcf_pkg::CSR_BLEND_GAIN: begin
               blend_gain_ff <= csr_write_data[tcf_pkg::BLEND_GAIN_W-1:0];
            end
            tcf_pkg::CSR_STEP_SCALE: begin
               step_scale_ff <= csr_write_data[tcf_pkg::STEP_SCALE_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // filter history, committed only when the result is handed over
   always_ff @(posedge clock) begin
      if (reset) begin
         gyro_integrator_ff     <= '0;
         prev_accel_angle_ff    <= '0;
         prev_accel_filtered_ff <= '0;
         prev_gyro_angle_ff     <= '0;
         prev_gyro_filtered_ff  <= '0;
         rsp_valid_ff           <= 1'b0;
      end else begin
         if (finish_fire) begin
            gyro_integrator_ff     <= g_raw_ff;
            prev_accel_angle_ff    <= a_raw_w;
            prev_accel_filtered_ff <= a_lp_ff;
            prev_gyro_angle_ff     <= g_raw_ff;
            prev_gyro_filtered_ff  <= g_hp_ff;
            rsp_valid_ff           <= 1'b1;
         end else if (rsp_fire) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // working registers and output payload
   always_ff @(posedge clock) begin
      case (state_ff)
         tcf_pkg::ST_IDLE: begin
            cnt_ff    <= '0;
            gyro_x_ff <= req_gyro_x;
            zero_ff   <= (req_accel_y == 16'sd0) && (req_accel_z == 16'sd0);
            if (req_accel_y[15]) begin
               // left half plane: rotate by pi first
               x_ff   <= -x_init;
               y_ff   <= -y_init;
               ang_ff <= num_w[16] ? -PI_ANG : PI_ANG;
            end else begin
               x_ff   <= x_init;
               y_ff   <= y_init;
               ang_ff <= '0;
            end
         end
         tcf_pkg::ST_CORDIC: begin
            cnt_ff <= cnt_ff + 1'b1;
            if (!y_ff[tcf_pkg::XY_W-1]) begin
               x_ff   <= x_ff + ys_w;
               y_ff   <= y_ff - xs_w;
               ang_ff <= ang_ff + t_w;
            end else begin
               x_ff   <= x_ff - ys_w;
               y_ff   <= y_ff + xs_w;
               ang_ff <= ang_ff - t_w;
            end
         end
         tcf_pkg::ST_MUL_GYRO: begin
            prod_ff <= prod_in;
         end
         tcf_pkg::ST_MUL_LP: begin
            g_raw_ff <= tcf_pkg::sat32(sum_w);
            prod_ff  <= prod_in;
         end
         tcf_pkg::ST_MUL_HP: begin
            a_lp_ff <= tcf_pkg::sat32(sum_w);
            prod_ff <= prod_in;
         end
         tcf_pkg::ST_HP: begin
            g_hp_ff <= tcf_pkg::sat32(sum_w);
         end
         tcf_pkg::ST_FINISH: begin
            if (finish_fire) begin
               out_a_raw_ff <= a_raw_w;
               out_g_raw_ff <= g_raw_ff;
               out_a_lp_ff  <= a_lp_ff;
               out_g_hp_ff  <= g_hp_ff;
               out_fused_ff <= fused_w;
            end
         end
         default: begin
         end
      endcase
   end

   a_accept_starts_cordic: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff == tcf_pkg::ST_CORDIC && cnt_ff == '0))
      else $error("accepted request did not start the CORDIC pass");

   a_cnt_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == tcf_pkg::ST_CORDIC) |-> (cnt_ff <= LAST_STEP))
      else $error("CORDIC step counter past last step");

   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == tcf_pkg::ST_FINISH))
      else $error("response raised outside the finish step");

   a_finish_holds_on_full: assert property (@(posedge clock) disable iff (reset)
      (state_ff == tcf_pkg::ST_FINISH && rsp_valid_ff && rsp_stall)
      |=> (state_ff == tcf_pkg::ST_FINISH && $stable(gyro_integrator_ff)))
      else $error("result committed while output register was full");

endmodule

// ----- tb/tilt_complementary_filter_test.sv -----
// Self-checking testbench for the tilt complementary filter: directed and random IMU requests vs. a predictor.
module tilt_complementary_filter_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ANGLE_FRAC   = 16;
   localparam int CORDIC_ITERS = 16;
   localparam int HOLD_CYCLES  = 300;

   // atan(2^-i), Q2.30
   localparam longint ATAN_Q30 [24] = '{
      843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
      16775851, 8388437, 4194283, 2097149, 1048576, 524288,
      262144, 131072, 65536, 32768, 16384, 8192,
      4096, 2048, 1024, 512, 256, 128
   };

   typedef struct {
      logic signed [15:0] accel_y;
      logic signed [15:0] accel_z;
      logic signed [15:0] gyro_x;
      bit                 wait_drain;
   } imu_sample_type;

   typedef struct {
      logic signed [31:0] accel_raw;
      logic signed [31:0] gyro_raw;
      logic signed [31:0] accel_lp;
      logic signed [31:0] gyro_hp;
      logic signed [31:0] fused;
   } tilt_angles_type;

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              req_valid = 1'b0;
   logic                              req_stall;
   logic signed [15:0]                req_accel_y = '0;
   logic signed [15:0]                req_accel_z = '0;
   logic signed [15:0]                req_gyro_x = '0;
   logic                              rsp_valid;
   logic                              rsp_stall = 1'b0;
   logic signed [31:0]                rsp_accel_angle_raw;
   logic signed [31:0]                rsp_gyro_angle_raw;
   logic signed [31:0]                rsp_accel_angle_low_passed;
   logic signed [31:0]                rsp_gyro_angle_high_passed;
   logic signed [31:0]                rsp_fused_angle;
   logic                              csr_write_enable = 1'b0;
   logic [tcf_pkg::CSR_INDEX_W-1:0]   csr_index = '0;
   logic [tcf_pkg::CSR_DATA_W-1:0]    csr_write_data = '0;

   tilt_complementary_filter uut (
      .clock                      (clock),
      .reset                      (reset),
      .req_valid                  (req_valid),
      .req_stall                  (req_stall),
      .req_accel_y                (req_accel_y),
      .req_accel_z                (req_accel_z),
      .req_gyro_x                 (req_gyro_x),
      .rsp_valid                  (rsp_valid),
      .rsp_stall                  (rsp_stall),
      .rsp_accel_angle_raw        (rsp_accel_angle_raw),
      .rsp_gyro_angle_raw         (rsp_gyro_angle_raw),
      .rsp_accel_angle_low_passed (rsp_accel_angle_low_passed),
      .rsp_gyro_angle_high_passed (rsp_gyro_angle_high_passed),
      .rsp_fused_angle            (rsp_fused_angle),
      .csr_write_enable           (csr_write_enable),
      .csr_index                  (csr_index),
      .csr_write_data             (csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor state and register copies
   logic [15:0]  alpha_gain = tcf_pkg::BLEND_GAIN_RST;
   logic [23:0]  rate_scale = tcf_pkg::STEP_SCALE_RST;
   int           integ_angle = 0;
   int           last_accel_angle = 0;
   int           last_accel_lp = 0;
   int           last_gyro_angle = 0;
   int           last_gyro_hp = 0;

   imu_sample_type  pending_samples[$];
   tilt_angles_type expected_angles[$];
   imu_sample_type  in_flight;
   bit           offering = 1'b0;
   int           gap_left = 0;
   int           stall_left = 0;
   int           hold_left = 0;
   int           results_seen = 0;
   int           fail_count = 0;
   bit           sender_idles = 1'b1;
   bit           receiver_idles = 1'b1;

   function automatic longint q30_to_fmt(longint v);
      return (v + (64'sd1 <<< (29 - ANGLE_FRAC))) >>> (30 - ANGLE_FRAC);
   endfunction

   function automatic int clamp32(longint v);
      if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return int'(v);
   endfunction

   function automatic int tilt_atan2(longint num, longint den);
      longint x, y, ang, xs, ys, t;
      x = den * 65536;
      y = num * 65536;
      ang = 0;
      if (num == 0 && den == 0) return 0;
      // left half plane: rotate by pi first, sign taken from y
      if (x < 0) begin
         ang = (y >= 0) ? q30_to_fmt(tcf_pkg::PI_Q30) : -q30_to_fmt(tcf_pkg::PI_Q30);
         x = -x;
         y = -y;
      end
      for (int i = 0; i < CORDIC_ITERS && i < 24; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         t = q30_to_fmt(ATAN_Q30[i]);
         if (y >= 0) begin
            x = x + ys;
            y = y - xs;
            ang = ang + t;
         end else begin
            x = x - ys;
            y = y + xs;
            ang = ang - t;
         end
      end
      return clamp32(ang);
   endfunction

   function automatic void predict_tilt(imu_sample_type s);
      longint ay, az, gx, a, scale, inc, d;
      tilt_angles_type r;
      ay = s.accel_y;
      az = s.accel_z;
      gx = s.gyro_x;
      a = alpha_gain;
      scale = rate_scale;
      r.accel_raw = tilt_atan2(-az, ay);
      inc = (gx * scale) >>> (32 - ANGLE_FRAC);
      r.gyro_raw = clamp32(longint'(integ_angle) + inc);
      integ_angle = r.gyro_raw;
      d = longint'(last_accel_angle) - longint'(last_accel_lp);
      r.accel_lp = clamp32(longint'(last_accel_lp) + ((a * d + 32768) >>> 16));
      r.gyro_hp = clamp32(longint'(r.gyro_raw) - longint'(last_gyro_angle)
                          + longint'(last_gyro_hp)
                          - ((a * longint'(last_gyro_hp) + 32768) >>> 16));
      r.fused = clamp32(longint'(r.accel_lp) + longint'(r.gyro_hp));
      last_accel_angle = r.accel_raw;
      last_accel_lp = r.accel_lp;
      last_gyro_angle = r.gyro_raw;
      last_gyro_hp = r.gyro_hp;
      expected_angles.push_back(r);
   endfunction

   function automatic int draw_gap(bit idles);
      return idles ? $urandom_range(0, 11) : 0;
   endfunction

   function automatic int draw_field();
      int v;
      case ($urandom_range(0, 7))
         0: v = -32768;
         1: v = 32767;
         2: v = 0;
         3: v = -1;
         default: v = int'($urandom & 32'hFFFF) - 32768;
      endcase
      return v;
   endfunction

   // strongly signed rate so the integrator runs into its rails
   function automatic int draw_rate(int bias);
      int mag;
      if (bias == 0) return draw_field();
      mag = ($urandom_range(0, 1) == 0) ? 32767 : $urandom_range(20000, 32767);
      return (bias > 0) ? mag : -mag - 1;
   endfunction

   function automatic void queue_sample(int ay, int az, int gx, bit drain);
      imu_sample_type s;
      s.accel_y = ay[15:0];
      s.accel_z = az[15:0];
      s.gyro_x = gx[15:0];
      s.wait_drain = drain;
      pending_samples.push_back(s);
   endfunction

   task automatic report_mismatch(string what, logic signed [31:0] got,
                                  logic signed [31:0] want);
      fail_count++;
      $display("mismatch at result %0d: %s got %0d, expected %0d",
               results_seen, what, got, want);
   endtask

   task automatic write_csr(logic [tcf_pkg::CSR_INDEX_W-1:0] idx,
                            logic [tcf_pkg::CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      if (idx == tcf_pkg::CSR_BLEND_GAIN) alpha_gain = data[15:0];
      else rate_scale = data;
   endtask

   task automatic wait_drained();
      while (pending_samples.size() != 0 || offering || expected_angles.size() != 0)
         @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   // request driver
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            predict_tilt(in_flight);
            offering = 1'b0;
            gap_left = draw_gap(sender_idles);
         end else if (!offering && gap_left > 0) begin
            gap_left--;
         end
         if (!offering && gap_left == 0 && pending_samples.size() != 0 &&
             (!pending_samples[0].wait_drain || expected_angles.size() == 0)) begin
            in_flight = pending_samples.pop_front();
            offering = 1'b1;
            req_accel_y <= in_flight.accel_y;
            req_accel_z <= in_flight.accel_z;
            req_gyro_x <= in_flight.gyro_x;
         end
         req_valid <= offering;
      end
   end

   // result monitor and receiver stalls
   always @(posedge clock) begin
      tilt_angles_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (expected_angles.size() == 0) begin
               report_mismatch("unexpected result, accel_angle_raw", rsp_accel_angle_raw, 0);
            end else begin
               want = expected_angles.pop_front();
               if (rsp_accel_angle_raw !== want.accel_raw)
                  report_mismatch("accel_angle_raw", rsp_accel_angle_raw, want.accel_raw);
               if (rsp_gyro_angle_raw !== want.gyro_raw)
                  report_mismatch("gyro_angle_raw", rsp_gyro_angle_raw, want.gyro_raw);
               if (rsp_accel_angle_low_passed !== want.accel_lp)
                  report_mismatch("accel_angle_low_passed", rsp_accel_angle_low_passed,
                                  want.accel_lp);
               if (rsp_gyro_angle_high_passed !== want.gyro_hp)
                  report_mismatch("gyro_angle_high_passed", rsp_gyro_angle_high_passed,
                                  want.gyro_hp);
               if (rsp_fused_angle !== want.fused)
                  report_mismatch("fused_angle", rsp_fused_angle, want.fused);
            end
            stall_left = draw_gap(receiver_idles);
            // long back-pressure so the block fills and stalls its input
            if (results_seen == 100 || results_seen == 600) hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      logic [15:0] blend;
      logic [23:0] scale;
      int bias, count;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed: zero vector, axes, pi pre-rotation both ways, extremes
      queue_sample(0, 0, 0, 1'b0);
      queue_sample(0, 0, 32767, 1'b0);
      queue_sample(32767, 0, -32768, 1'b0);
      queue_sample(-32768, 0, 0, 1'b0);
      queue_sample(-32768, 1, 1, 1'b0);
      queue_sample(-32768, -1, -1, 1'b0);
      queue_sample(-1, 0, 32767, 1'b0);
      queue_sample(-1, -1, -1, 1'b0);
      queue_sample(-32768, -32768, 32767, 1'b0);
      queue_sample(-32768, 32767, -32768, 1'b1);
      queue_sample(32767, 32767, 32767, 1'b0);
      queue_sample(32767, -32768, -32768, 1'b0);
      queue_sample(0, 32767, 100, 1'b0);
      queue_sample(0, -32768, -100, 1'b0);
      queue_sample(1, 0, 0, 1'b0);
      queue_sample(0, 1, 0, 1'b0);
      queue_sample(0, -1, 0, 1'b0);
      queue_sample(12345, -23456, 1000, 1'b0);
      queue_sample(-20000, 5000, -5000, 1'b0);
      queue_sample(32767, 1, 32767, 1'b0);
      wait_drained();

      for (int p = 0; p < 5; p++) begin
         case (p)
            0: begin
               blend = 16'd0; scale = 24'hFFFFFF; bias = -1; count = 300;
               sender_idles = 1'b1; receiver_idles = 1'b1;
            end
            1: begin
               blend = 16'hFFFF; scale = 24'hFFFFFF; bias = 1; count = 300;
               sender_idles = 1'b0; receiver_idles = 1'b0;
            end
            2: begin
               blend = 16'd0; scale = 24'hFFFFFF; bias = 1; count = 300;
               sender_idles = 1'b1; receiver_idles = 1'b0;
            end
            3: begin
               blend = tcf_pkg::BLEND_GAIN_RST; scale = 24'd0; bias = 0; count = 100;
               sender_idles = 1'b0; receiver_idles = 1'b1;
            end
            default: begin
               blend = 16'($urandom_range(0, 65535));
               scale = 24'($urandom_range(0, 24'hFFFFFF));
               bias = 0; count = 100;
               sender_idles = 1'b1; receiver_idles = 1'b1;
            end
         endcase
         write_csr(tcf_pkg::CSR_BLEND_GAIN, tcf_pkg::CSR_DATA_W'(blend));
         write_csr(tcf_pkg::CSR_STEP_SCALE, scale);
         repeat (count)
            queue_sample(draw_field(), draw_field(), draw_rate(bias),
                         $urandom_range(0, 39) == 0);
         wait_drained();
      end

      if (fail_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   initial begin
      #5000000;
      $display("TEST FAILED");
      $finish;
   end

endmodule

// ----- files.f -----
rtl/tcf_pkg.sv
rtl/tilt_complementary_filter.sv
tb/tilt_complementary_filter_test.sv
